// ----- src/npic_pkg.sv -----
// shared types and constants for the nested priority interrupt controller
// no dependencies; imported by every module of the block
`default_nettype none

package npic_pkg;

    // default number of priority levels
    localparam int NPIC_NUM_LEVELS = 4;

    // fixed field widths
    localparam int LVL_W = 3;
    localparam int CNT_W = 4;

    // work count after reset
    localparam logic [CNT_W-1:0] WORK_RESET = 4'd5;

    // input beat kind
    typedef enum logic
    {
        OP_REQUEST = 1'b0,
        OP_TICK    = 1'b1
    } opcode_t;

    // result status codes
    typedef enum logic [2:0]
    {
        ST_IDLE    = 3'd0,
        ST_UNIT    = 3'd1,
        ST_PENDING = 3'd2,
        ST_ACCEPT  = 3'd3,
        ST_INVALID = 3'd4
    } status_t;

    // one registered input beat
    typedef struct packed
    {
        opcode_t          opcode;
        logic [LVL_W-1:0] prio;
    } item_t;

    // fixed-width part of one result beat
    typedef struct packed
    {
        status_t          status;
        logic [LVL_W-1:0] event_prio;
        logic [LVL_W-1:0] active;
    } res_t;

endpackage

`default_nettype wire

// ----- src/npic_in_reg.sv -----
// input register stage of the interrupt controller
// depends on npic_pkg (item_t, opcode_t)
`default_nettype none

module npic_in_reg import npic_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic             opcode,
    input  wire logic [LVL_W-1:0] request_priority,
    input  wire logic             advance,
    output logic                  item_valid,
    output item_t                 item
);

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    // hold off only when a beat is parked here and the step cannot take it
    assign in_stall   = valid_reg && !advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        item_next.opcode = opcode_t'(opcode);
        item_next.prio   = request_priority;
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/npic_core.sv -----
// controller state and the combinational step logic for one beat
// depends on npic_pkg (item_t, res_t, status and opcode codes)
`default_nettype none

module npic_core import npic_pkg::*;
#(
    parameter int NUM_LEVELS = NPIC_NUM_LEVELS
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              fire,
    input  wire item_t                             item,
    input  wire logic                              cfg_we,
    input  wire logic [CNT_W-1:0]                  cfg_data,
    output res_t                                   res,
    output logic [NUM_LEVELS-1:0]                  res_pending,
    output logic [$clog2(NUM_LEVELS+1)-1:0]        res_depth
);

    localparam int DEPTH_W = $clog2(NUM_LEVELS+1);

    // architectural state; the stack is a level mask plus a counter per level
    logic [NUM_LEVELS-1:0] pending_reg;
    logic [NUM_LEVELS-1:0] pending_next;
    logic [NUM_LEVELS-1:0] mask_reg;
    logic [NUM_LEVELS-1:0] mask_next;
    logic [LVL_W-1:0]      active_reg;
    logic [LVL_W-1:0]      active_next;
    logic [DEPTH_W-1:0]    depth_reg;
    logic [DEPTH_W-1:0]    depth_next;
    logic [CNT_W-1:0]      remain_reg [NUM_LEVELS];
    logic [CNT_W-1:0]      remain_next [NUM_LEVELS];
    logic [CNT_W-1:0]      work_reg;

    // step temporaries
    logic [CNT_W-1:0]      count;
    logic [LVL_W-1:0]      hp;
    logic                  start;
    logic [LVL_W-1:0]      act1;
    logic [NUM_LEVELS-1:0] mask1;
    logic [NUM_LEVELS-1:0] mask2;
    logic [DEPTH_W-1:0]    depth1;
    logic [CNT_W-1:0]      cur;
    logic [CNT_W-1:0]      rem_dec;
    logic [LVL_W-1:0]      below;
    status_t               status;
    logic [LVL_W-1:0]      event_prio;
    logic                  has_room;

    always_comb
    begin
        // a zero work count behaves as one
        count    = (work_reg == '0) ? CNT_W'(1) : work_reg;
        has_room = int'(depth_reg) < NUM_LEVELS;

        // highest pending level
        hp = '0;
        for (int k = 0; k < NUM_LEVELS; k++)
        begin
            if (pending_reg[k])
            begin
                hp = LVL_W'(k + 1);
            end
        end

        // defaults: state holds
        pending_next = pending_reg;
        mask_next    = mask_reg;
        active_next  = active_reg;
        depth_next   = depth_reg;
        for (int k = 0; k < NUM_LEVELS; k++)
        begin
            remain_next[k] = remain_reg[k];
        end
        status     = ST_IDLE;
        event_prio = '0;
        start      = 1'b0;
        act1       = active_reg;
        mask1      = mask_reg;
        mask2      = mask_reg;
        depth1     = depth_reg;
        cur        = '0;
        rem_dec    = '0;
        below      = '0;

        case (item.opcode)
            OP_REQUEST:
            begin
                if (item.prio == '0 || int'(item.prio) > NUM_LEVELS)
                begin
                    status = ST_INVALID;
                end
                else if (item.prio > active_reg)
                begin
                    // preempt: push the level with a fresh count when the stack has room
                    status     = ST_ACCEPT;
                    event_prio = item.prio;
                    if (has_room)
                    begin
                        for (int k = 0; k < NUM_LEVELS; k++)
                        begin
                            if (int'(item.prio) == k + 1)
                            begin
                                mask_next[k]   = 1'b1;
                                remain_next[k] = count;
                            end
                        end
                        depth_next  = depth_reg + DEPTH_W'(1);
                        active_next = item.prio;
                    end
                end
                else
                begin
                    // equal or lower: merge into pending
                    status     = ST_PENDING;
                    event_prio = item.prio;
                    for (int k = 0; k < NUM_LEVELS; k++)
                    begin
                        if (int'(item.prio) == k + 1)
                        begin
                            pending_next[k] = 1'b1;
                        end
                    end
                end
            end
            OP_TICK:
            begin
                // start the highest pending level if it outranks the active one and the stack has room
                start = (hp > active_reg) && has_room;
                if (start)
                begin
                    act1   = hp;
                    depth1 = depth_reg + DEPTH_W'(1);
                    for (int k = 0; k < NUM_LEVELS; k++)
                    begin
                        if (int'(hp) == k + 1)
                        begin
                            pending_next[k] = 1'b0;
                            mask1[k]        = 1'b1;
                        end
                    end
                end

                // work count of the top level
                for (int k = 0; k < NUM_LEVELS; k++)
                begin
                    if (int'(act1) == k + 1)
                    begin
                        cur = remain_reg[k];
                    end
                end
                if (start)
                begin
                    cur = count;
                end
                rem_dec = (cur != '0) ? cur - CNT_W'(1) : '0;

                if (depth1 == '0)
                begin
                    status      = ST_IDLE;
                    active_next = '0;
                end
                else
                begin
                    status     = ST_UNIT;
                    event_prio = act1;
                    for (int k = 0; k < NUM_LEVELS; k++)
                    begin
                        if (int'(act1) == k + 1)
                        begin
                            remain_next[k] = rem_dec;
                        end
                    end
                    mask_next   = mask1;
                    depth_next  = depth1;
                    active_next = act1;

                    // done: pop and resume the level below
                    if (rem_dec == '0)
                    begin
                        mask2 = mask1;
                        for (int k = 0; k < NUM_LEVELS; k++)
                        begin
                            if (int'(act1) == k + 1)
                            begin
                                mask2[k] = 1'b0;
                            end
                        end
                        for (int k = 0; k < NUM_LEVELS; k++)
                        begin
                            if (mask2[k])
                            begin
                                below = LVL_W'(k + 1);
                            end
                        end
                        mask_next   = mask2;
                        depth_next  = depth1 - DEPTH_W'(1);
                        active_next = below;
                    end
                end
            end
            default:
            begin
                status = ST_IDLE;
            end
        endcase
    end

    // result of this step
    always_comb
    begin
        res.status     = status;
        res.event_prio = event_prio;
        res.active     = active_next;
    end
    assign res_pending = pending_next;
    assign res_depth   = depth_next;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            mask_reg    <= '0;
            active_reg  <= '0;
            depth_reg   <= '0;
        end
        else if (fire)
        begin
            pending_reg <= pending_next;
            mask_reg    <= mask_next;
            active_reg  <= active_next;
            depth_reg   <= depth_next;
        end
    end

    // work count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            work_reg <= WORK_RESET;
        end
        else if (cfg_we)
        begin
            work_reg <= cfg_data;
        end
    end

    // per-level counters, meaningful only while the level is stacked
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            for (int k = 0; k < NUM_LEVELS; k++)
            begin
                remain_reg[k] <= remain_next[k];
            end
        end
    end

endmodule

`default_nettype wire

// ----- src/npic_out_reg.sv -----
// result register stage of the interrupt controller
// depends on npic_pkg (res_t)
`default_nettype none

module npic_out_reg import npic_pkg::*;
#(
    parameter int NUM_LEVELS = NPIC_NUM_LEVELS
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              load,
    input  wire res_t                              res,
    input  wire logic [NUM_LEVELS-1:0]             res_pending,
    input  wire logic [$clog2(NUM_LEVELS+1)-1:0]   res_depth,
    output logic                                   advance,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [LVL_W-1:0]                       status,
    output logic [LVL_W-1:0]                       event_priority,
    output logic [LVL_W-1:0]                       active_level,
    output logic [NUM_LEVELS-1:0]                  pending_mask,
    output logic [$clog2(NUM_LEVELS+1)-1:0]        nesting_depth
);

    localparam int DEPTH_W = $clog2(NUM_LEVELS+1);

    logic                  valid_reg;
    res_t                  res_reg;
    logic [NUM_LEVELS-1:0] pending_reg;
    logic [DEPTH_W-1:0]    depth_reg;

    // room for a new beat when empty or the held beat leaves now
    assign advance   = !valid_reg || !out_stall;
    assign out_valid = valid_reg;

    assign status         = LVL_W'(res_reg.status);
    assign event_priority = res_reg.event_prio;
    assign active_level   = res_reg.active;
    assign pending_mask   = pending_reg;
    assign nesting_depth  = depth_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= load;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg     <= res;
            pending_reg <= res_pending;
            depth_reg   <= res_depth;
        end
    end

endmodule

`default_nettype wire

// ----- src/nested_priority_interrupt_controller.sv -----
// Nested priority interrupt controller: each input beat is a request with a
// priority or a tick, and each one yields exactly one result beat. A request
// above the active level preempts and is stacked with a work count of ticks;
// others merge into the pending mask; a tick starts the highest pending level
// if it outranks the active one, then does one unit of the active level's work
// and pops it when the count runs out. The block takes one beat per clock
// while the result side does not stall; a beat passes the input register and
// then the result register, with the whole step and state update done between
// them. The work count register is written through cfg_valid/cfg_data, which
// is always ready; write it only while no beat is in flight. No clearing pass
// is run after reset.
// depends on npic_pkg, npic_in_reg, npic_core, npic_out_reg
`default_nettype none

module nested_priority_interrupt_controller import npic_pkg::*;
#(
    parameter int NUM_LEVELS = NPIC_NUM_LEVELS
)
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [CNT_W-1:0]                  cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              opcode,
    input  wire logic [LVL_W-1:0]                  request_priority,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [LVL_W-1:0]                       status,
    output logic [LVL_W-1:0]                       event_priority,
    output logic [LVL_W-1:0]                       active_level,
    output logic [NUM_LEVELS-1:0]                  pending_mask,
    output logic [$clog2(NUM_LEVELS+1)-1:0]        nesting_depth
);

    localparam int DEPTH_W = $clog2(NUM_LEVELS+1);

    logic                  item_valid;
    item_t                 item;
    logic                  advance;
    logic                  fire;
    res_t                  res;
    logic [NUM_LEVELS-1:0] res_pending;
    logic [DEPTH_W-1:0]    res_depth;

    assign cfg_ready = 1'b1;
    assign fire      = item_valid && advance;

    // input register
    npic_in_reg u_in_reg
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .opcode           (opcode),
        .request_priority (request_priority),
        .advance          (advance),
        .item_valid       (item_valid),
        .item             (item)
    );

    // state and step logic
    npic_core #(.NUM_LEVELS(NUM_LEVELS)) u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (fire),
        .item        (item),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .res         (res),
        .res_pending (res_pending),
        .res_depth   (res_depth)
    );

    // result register
    npic_out_reg #(.NUM_LEVELS(NUM_LEVELS)) u_out_reg
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (fire),
        .res            (res),
        .res_pending    (res_pending),
        .res_depth      (res_depth),
        .advance        (advance),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .event_priority (event_priority),
        .active_level   (active_level),
        .pending_mask   (pending_mask),
        .nesting_depth  (nesting_depth)
    );

    // input holds off only behind a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while result stage could move");

    // empty stack and idle active level go together
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((nesting_depth == '0) == (active_level == '0)))
        else $error("nesting depth and active level disagree");

    // invalid requests and idle ticks name no level
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == LVL_W'(ST_INVALID) || status == LVL_W'(ST_IDLE)))
        |-> (event_priority == '0))
        else $error("event priority set on invalid or idle result");

    // a processed unit concerns a level at or above the resulting active level
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == LVL_W'(ST_UNIT)) |-> (event_priority >= active_level))
        else $error("processed unit below active level");

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// self-checking testbench for the nested priority interrupt controller
// drives requests and ticks over the stall handshake and checks every result beat
// against the behavioral model or a pinned row's result; depends on npic_pkg and the rtl top

module tb_top;
    import npic_pkg::*;

    // one result beat as predicted
    typedef struct packed
    {
        status_t    status;
        logic [2:0] event_prio;
        logic [2:0] active;
        logic [3:0] pending;
        logic [2:0] depth;
    } ctl_result_t;

    // directed stimulus row; pinned rows carry a hand-written result
    typedef struct
    {
        opcode_t     op;
        logic [2:0]  prio;
        bit          pinned;
        ctl_result_t want;
    } stim_row_t;

    typedef struct
    {
        bit          pinned;
        ctl_result_t want;
    } pin_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [3:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic       opcode;
    logic [2:0] request_priority;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] status;
    logic [2:0] event_priority;
    logic [2:0] active_level;
    logic [3:0] pending_mask;
    logic [2:0] nesting_depth;

    // model state of the controller
    logic [3:0] pend_bits;
    logic [2:0] act_lvl;
    logic [2:0] lvl_stk [4];
    logic [3:0] rem_stk [4];
    logic [2:0] depth_cnt;
    logic [3:0] work_cnt;

    ctl_result_t expected_events [$];
    pin_t        pinned_results [$];
    stim_row_t   directed_rows [$];

    int err_cnt;
    int tx_pct;
    int rx_pct;
    int hold_requests;
    int hold_served;

    int phase_work [6] = '{1, 15, 0, 7, 3, 0};
    int phase_tx   [6] = '{0, 84, 0, 14, 0, 30};
    int phase_rx   [6] = '{0, 0, 84, 14, 0, 30};

    nested_priority_interrupt_controller u_top
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .opcode           (opcode),
        .request_priority (request_priority),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .event_priority   (event_priority),
        .active_level     (active_level),
        .pending_mask     (pending_mask),
        .nesting_depth    (nesting_depth)
    );

    // clock
    always #6 clk = ~clk;

    // stack a level with a fresh work count, unless the stack is full
    function automatic void push_level(logic [2:0] lvl);
        if (depth_cnt >= 3'd4)
            return;
        lvl_stk[depth_cnt[1:0]] = lvl;
        rem_stk[depth_cnt[1:0]] = (work_cnt == 4'd0) ? 4'd1 : work_cnt;
        depth_cnt = depth_cnt + 3'd1;
        act_lvl = lvl;
    endfunction

    // apply one request or tick to the model state, return the result beat
    function automatic ctl_result_t advance_controller(opcode_t op, logic [2:0] prio);
        ctl_result_t r;
        logic [2:0]  next;
        logic [2:0]  top;
        r = '0;
        if (op == OP_REQUEST) begin
            if (prio < 3'd1 || prio > 3'd4) begin
                r.status = ST_INVALID;
            end
            else if (prio > act_lvl) begin
                push_level(prio);
                r.status = ST_ACCEPT;
                r.event_prio = prio;
            end
            else begin
                pend_bits[prio - 3'd1] = 1'b1;
                r.status = ST_PENDING;
                r.event_prio = prio;
            end
        end
        else begin
            // highest pending level
            next = 3'd0;
            for (int l = 4; l >= 1; l--)
                if (next == 3'd0 && pend_bits[l-1])
                    next = 3'(l);
            if (next > act_lvl && depth_cnt < 3'd4) begin
                pend_bits[next - 3'd1] = 1'b0;
                push_level(next);
            end
            if (depth_cnt == 3'd0) begin
                act_lvl = 3'd0;
                r.status = ST_IDLE;
            end
            else begin
                top = depth_cnt - 3'd1;
                r.event_prio = lvl_stk[top[1:0]];
                r.status = ST_UNIT;
                if (rem_stk[top[1:0]] > 4'd0)
                    rem_stk[top[1:0]] = rem_stk[top[1:0]] - 4'd1;
                if (rem_stk[top[1:0]] == 4'd0) begin
                    depth_cnt = top;
                    act_lvl = (top > 3'd0) ? lvl_stk[top[1:0] - 2'd1] : 3'd0;
                end
            end
        end
        r.active = act_lvl;
        r.pending = pend_bits;
        r.depth = depth_cnt;
        return r;
    endfunction

    function automatic void add_row(opcode_t op, logic [2:0] prio, bit pinned,
                                    status_t st, int ev, int act, int pend, int depth);
        stim_row_t row;
        row.op = op;
        row.prio = prio;
        row.pinned = pinned;
        row.want.status = st;
        row.want.event_prio = 3'(ev);
        row.want.active = 3'(act);
        row.want.pending = 4'(pend);
        row.want.depth = 3'(depth);
        directed_rows.push_back(row);
    endfunction

    task automatic check_field(string name, int unsigned want_v, int unsigned got_v);
        if (want_v != got_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            err_cnt++;
        end
    endtask

    // offer one beat, hold it until accepted, then idle cycle by cycle
    task automatic send_beat(opcode_t op, logic [2:0] prio, bit pinned, ctl_result_t want);
        pin_t p;
        p.pinned = pinned;
        p.want = want;
        pinned_results.push_back(p);
        in_valid <= 1'b1;
        opcode <= op;
        request_priority <= prio;
        do
            @(posedge clk);
        while (in_stall);
        while ($urandom_range(99) < tx_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (expected_events.size() != 0 || pinned_results.size() != 0)
            @(posedge clk);
    endtask

    // track config writes, predict accepted beats, check result beats
    always @(posedge clk) begin
        ctl_result_t want;
        pin_t        pin;
        if (rst_n) begin
            if (cfg_valid && cfg_ready)
                work_cnt = cfg_data;
            if (in_valid && !in_stall) begin
                want = advance_controller(opcode_t'(opcode), request_priority);
                pin = pinned_results.pop_front();
                if (pin.pinned)
                    want = pin.want;
                expected_events.push_back(want);
            end
            if (out_valid && !out_stall) begin
                if (expected_events.size() == 0) begin
                    $error("result beat with no beat expected");
                    err_cnt++;
                end
                else begin
                    want = expected_events.pop_front();
                    check_field("status", want.status, status);
                    check_field("event_priority", want.event_prio, event_priority);
                    check_field("active_level", want.active, active_level);
                    check_field("pending_mask", want.pending, pending_mask);
                    check_field("nesting_depth", want.depth, nesting_depth);
                end
            end
        end
    end

    // result side: random stall, or a long hold-off when asked for
    initial begin
        forever begin
            @(posedge clk);
            if (hold_requests != hold_served) begin
                out_stall <= 1'b1;
                repeat (64) @(posedge clk);
                hold_served++;
            end
            else begin
                out_stall <= ($urandom_range(99) < rx_pct);
            end
        end
    end

    // run limit
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // reset, directed table, then random phases
    initial begin
        int          v;
        opcode_t     op;
        logic [2:0]  prio;
        ctl_result_t none;
        clk = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 4'd0;
        in_valid = 1'b0;
        opcode = 1'b0;
        request_priority = 3'd0;
        out_stall = 1'b0;
        err_cnt = 0;
        tx_pct = 0;
        rx_pct = 0;
        hold_requests = 0;
        hold_served = 0;
        none = '0;
        pend_bits = 4'd0;
        act_lvl = 3'd0;
        depth_cnt = 3'd0;
        work_cnt = WORK_RESET;
        for (int i = 0; i < 4; i++) begin
            lvl_stk[i] = 3'd0;
            rem_stk[i] = 4'd0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle tick, invalid priorities, preemption, merging, equal level
        add_row(OP_TICK,    3'd0, 1, ST_IDLE,    0, 0, 0, 0);
        add_row(OP_REQUEST, 3'd0, 1, ST_INVALID, 0, 0, 0, 0);
        add_row(OP_REQUEST, 3'd7, 1, ST_INVALID, 0, 0, 0, 0);
        add_row(OP_REQUEST, 3'd5, 1, ST_INVALID, 0, 0, 0, 0);
        add_row(OP_REQUEST, 3'd2, 1, ST_ACCEPT,  2, 2, 0, 1);
        add_row(OP_REQUEST, 3'd1, 1, ST_PENDING, 1, 2, 1, 1);
        add_row(OP_REQUEST, 3'd1, 1, ST_PENDING, 1, 2, 1, 1);
        add_row(OP_REQUEST, 3'd2, 1, ST_PENDING, 2, 2, 3, 1);
        add_row(OP_REQUEST, 3'd4, 1, ST_ACCEPT,  4, 4, 3, 2);
        add_row(OP_REQUEST, 3'd3, 1, ST_PENDING, 3, 4, 7, 2);
        // tick ignores its priority field
        add_row(OP_TICK,    3'd7, 1, ST_UNIT,    4, 4, 7, 2);
        // drain through pops and pending starts
        for (int i = 0; i < 14; i++)
            add_row(OP_TICK, 3'(i), 0, ST_IDLE, 0, 0, 0, 0);
        foreach (directed_rows[i])
            send_beat(directed_rows[i].op, directed_rows[i].prio,
                      directed_rows[i].pinned, directed_rows[i].want);
        in_valid <= 1'b0;

        for (int ph = 0; ph < 6; ph++) begin
            wait_drained();
            repeat (4) @(posedge clk);
            // work count write while nothing is in flight
            v = (ph == 5) ? $urandom_range(15) : phase_work[ph];
            cfg_valid <= 1'b1;
            cfg_data <= 4'(v);
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_valid <= 1'b0;
            tx_pct = phase_tx[ph];
            rx_pct = phase_rx[ph];

            for (int n = 0; n < 96; n++) begin
                // pressure phase: long receiver hold-off, later a full drain
                if (ph == 4 && n == 10)
                    hold_requests++;
                if (ph == 4 && n == 60) begin
                    in_valid <= 1'b0;
                    wait_drained();
                end
                v = $urandom_range(99);
                if (v < 45) begin
                    op = OP_TICK;
                    prio = 3'($urandom_range(7));
                end
                else if (v < 90) begin
                    op = OP_REQUEST;
                    prio = 3'($urandom_range(1, 4));
                end
                else begin
                    op = OP_REQUEST;
                    v = $urandom_range(4, 7);
                    prio = (v == 4) ? 3'd0 : 3'(v);
                end
                send_beat(op, prio, 0, none);
            end
            in_valid <= 1'b0;
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/npic_pkg.sv
src/npic_in_reg.sv
src/npic_core.sv
src/npic_out_reg.sv
src/nested_priority_interrupt_controller.sv
sim/tb_top.sv
